@@ hdl/lsb_pkg.sv @@
package lsb_pkg;

    typedef logic [30:0]           tick_t;
    typedef logic [47:0]           total_t;
    typedef logic [31:0]           count_t;
    typedef logic [2:0][30:0]      tuple_t;   // [0] dma, [1] busy, [2] flush
    typedef logic [2:0][47:0]      totals_t;  // [0] dma, [1] busy, [2] flush

    typedef enum logic [1:0] {
        FUNC_RECORD = 2'd0,
        FUNC_READ   = 2'd1,
        FUNC_CLEAR  = 2'd2
    } func_t;

    typedef enum logic [2:0] {
        KIND_TOTALS    = 3'd0,
        KIND_MIN_DMA   = 3'd1,
        KIND_MAX_DMA   = 3'd2,
        KIND_MIN_BUSY  = 3'd3,
        KIND_MAX_BUSY  = 3'd4,
        KIND_MIN_FLUSH = 3'd5,
        KIND_MAX_FLUSH = 3'd6
    } kind_t;

    localparam int NUM_SLOTS = 6;

    localparam logic [2:0] SLOT_MIN_DMA   = 3'd0;
    localparam logic [2:0] SLOT_MIN_BUSY  = 3'd2;
    localparam logic [2:0] SLOT_MIN_FLUSH = 3'd4;

    localparam total_t TOTAL_MAX = '1;
    localparam count_t COUNT_MAX = '1;

    function automatic tuple_t clear_tuple(logic [2:0] slot, logic cache_on, tick_t tmax);
        tuple_t res;
        res = '0;
        if (slot == SLOT_MIN_DMA || slot == SLOT_MIN_BUSY)
        begin
            res[0] = tmax;
            res[1] = tmax;
            res[2] = cache_on ? tmax : '0;
        end
        else if (slot == SLOT_MIN_FLUSH && cache_on)
        begin
            res[0] = tmax;
            res[1] = tmax;
            res[2] = tmax;
        end
        return res;
    endfunction

    function automatic tuple_t update_extreme(tuple_t stored, tuple_t smp, logic [1:0] key,
                                              logic is_min);
        tuple_t res;
        logic   hit;
        res = stored;
        hit = is_min ? (stored[key] > smp[key]) : (stored[key] < smp[key]);
        if (hit)
        begin
            res = (smp[key] == '0) ? '0 : smp;
        end
        return res;
    endfunction

endpackage

@@ hdl/lsb_if.sv @@
interface lsb_item_if;
    logic                 valid;
    logic                 ready;
    logic [1:0]           func;
    logic [31:0]          write_size;
    lsb_pkg::tick_t       dma_ticks;
    lsb_pkg::tick_t       busy_ticks;
    lsb_pkg::tick_t       flush_ticks;
    logic [3:0]           bin_index;

    modport source (output valid, func, write_size, dma_ticks, busy_ticks, flush_ticks,
                    bin_index, input ready);
    modport sink   (input valid, func, write_size, dma_ticks, busy_ticks, flush_ticks,
                    bin_index, output ready);
endinterface

interface lsb_result_if;
    logic                 valid;
    logic                 ready;
    logic [2:0]           stat_kind;
    lsb_pkg::total_t      value_dma;
    lsb_pkg::total_t      value_busy;
    lsb_pkg::total_t      value_flush;
    lsb_pkg::count_t      sample_count;
    logic                 last;

    modport source (output valid, stat_kind, value_dma, value_busy, value_flush,
                    sample_count, last, input ready);
    modport sink   (input valid, stat_kind, value_dma, value_busy, value_flush,
                    sample_count, last, output ready);
endinterface

@@ hdl/latency_stats_per_size_bin.sv @@
// Channel  | Dir | Transaction
// ---------+-----+------------------------------------------------------------
// item     | in  | func, write_size, dma/busy/flush ticks, bin_index
// result   | out | stat_kind, value_dma/busy/flush, sample_count, last
// APB      | in  | cache_mode at address 0
//
// Record and clear: one transaction per cycle, applied in the cycle after acceptance.
// Read: snapshots the bin, then streams seven results, one per cycle through the
// output register; a following read waits until the last result is loaded.
// Reset (async, rst_n low) restores all bins as after a clear with cache mode off.
// Result stalls hold the output register; the item side keeps taking transactions
// until a second read waits behind the one streaming.
module latency_stats_per_size_bin #(
    parameter int NUM_BINS  = 9,
    parameter int BASE_SIZE = 8,
    parameter int TICK_MAX  = 2147483647
) (
    input  logic               clk,
    input  logic               rst_n,
    lsb_item_if.sink           item,
    lsb_result_if.source       result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [0:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import lsb_pkg::*;

    localparam int                 BIN_W    = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam logic [BIN_W-1:0]   LAST_BIN = BIN_W'(NUM_BINS - 1);
    localparam tick_t              TMAX     = tick_t'(TICK_MAX);
    localparam logic [63:0]        BASE64   = 64'(BASE_SIZE);

    // config
    logic cache_mode_reg;

    assign pready = 1'b1;
    assign prdata = (paddr == 1'b0) ? {31'b0, cache_mode_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cache_mode_reg <= 1'b0;
        else if (psel && penable && pwrite && paddr == 1'b0)
            cache_mode_reg <= pwdata[0];
    end

    // input register
    logic        in_valid_reg, in_valid_next;
    logic [1:0]  in_func_reg;
    logic [31:0] in_size_reg;
    tuple_t      in_tk_reg;
    logic [3:0]  in_index_reg;
    logic        in_consume;
    logic        item_take;

    logic        rd_active_reg, rd_active_next;
    kind_t       rd_kind_reg, rd_kind_next;
    count_t      rd_count_reg;
    totals_t     rd_totals_reg;
    tuple_t      rd_tuple_reg [NUM_SLOTS];

    assign in_consume = in_valid_reg && (in_func_reg != FUNC_READ || !rd_active_reg);
    assign item.ready = !in_valid_reg || in_consume;
    assign item_take  = item.valid && item.ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (item_take)
            in_valid_next = 1'b1;
        else if (in_consume)
            in_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            in_func_reg  <= item.func;
            in_size_reg  <= item.write_size;
            in_tk_reg    <= {item.flush_ticks, item.busy_ticks, item.dma_ticks};
            in_index_reg <= item.bin_index;
        end
    end

    // bin select
    logic [BIN_W-1:0] rec_bin, rd_bin, sel_bin;

    always_comb
    begin
        rec_bin = LAST_BIN;
        for (int k = 0; k < NUM_BINS; k++)
        begin
            if ((BASE64 << k) <= {32'b0, in_size_reg})
                rec_bin = BIN_W'(k);
        end
        if (in_size_reg == '0)
            rec_bin = '0;
    end

    assign rd_bin  = ({1'b0, in_index_reg} >= 5'(NUM_BINS)) ? LAST_BIN
                                                             : BIN_W'(in_index_reg);
    assign sel_bin = (in_func_reg == FUNC_READ) ? rd_bin : rec_bin;

    // bin state
    count_t  count_reg [NUM_BINS];
    totals_t total_reg [NUM_BINS];
    tuple_t  tuple_reg [NUM_BINS][NUM_SLOTS];

    count_t  cur_count, count_next;
    totals_t cur_total, total_next;
    tuple_t  cur_tuple  [NUM_SLOTS];
    tuple_t  tuple_next [NUM_SLOTS];
    logic [48:0] sum;

    always_comb
    begin
        cur_count = count_reg[sel_bin];
        cur_total = total_reg[sel_bin];
        for (int s = 0; s < NUM_SLOTS; s++)
            cur_tuple[s] = tuple_reg[sel_bin][s];
    end

    always_comb
    begin
        sum        = '0;
        count_next = (cur_count == COUNT_MAX) ? cur_count : cur_count + 32'd1;
        for (int j = 0; j < 3; j++)
        begin
            sum           = {1'b0, cur_total[j]} + 49'(in_tk_reg[j]);
            total_next[j] = sum[48] ? TOTAL_MAX : sum[47:0];
        end
        for (int s = 0; s < NUM_SLOTS; s++)
        begin
            if (s < 4 || cache_mode_reg)
                tuple_next[s] = update_extreme(cur_tuple[s], in_tk_reg, 2'(s >> 1),
                                               (s % 2) == 0);
            else
                tuple_next[s] = cur_tuple[s];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < NUM_BINS; b++)
            begin
                count_reg[b] <= '0;
                total_reg[b] <= '0;
                for (int s = 0; s < NUM_SLOTS; s++)
                    tuple_reg[b][s] <= clear_tuple(3'(s), 1'b0, TMAX);
            end
        end
        else if (in_consume && in_func_reg == FUNC_CLEAR)
        begin
            for (int b = 0; b < NUM_BINS; b++)
            begin
                count_reg[b] <= '0;
                total_reg[b] <= '0;
                for (int s = 0; s < NUM_SLOTS; s++)
                    tuple_reg[b][s] <= clear_tuple(3'(s), cache_mode_reg, TMAX);
            end
        end
        else if (in_consume && in_func_reg == FUNC_RECORD)
        begin
            count_reg[sel_bin] <= count_next;
            total_reg[sel_bin] <= total_next;
            for (int s = 0; s < NUM_SLOTS; s++)
                tuple_reg[sel_bin][s] <= tuple_next[s];
        end
    end

    // read snapshot and stream
    logic rd_start, out_load;

    assign rd_start = in_consume && in_func_reg == FUNC_READ;
    assign out_load = rd_active_reg && (!result.valid || result.ready);

    always_comb
    begin
        rd_active_next = rd_active_reg;
        rd_kind_next   = rd_kind_reg;
        if (rd_start)
        begin
            rd_active_next = 1'b1;
            rd_kind_next   = KIND_TOTALS;
        end
        else if (out_load)
        begin
            if (rd_kind_reg == KIND_MAX_FLUSH)
                rd_active_next = 1'b0;
            else
                rd_kind_next = kind_t'(rd_kind_reg + 3'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_active_reg <= 1'b0;
            rd_kind_reg   <= KIND_TOTALS;
        end
        else
        begin
            rd_active_reg <= rd_active_next;
            rd_kind_reg   <= rd_kind_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_start)
        begin
            rd_count_reg  <= cur_count;
            rd_totals_reg <= cur_total;
            for (int s = 0; s < NUM_SLOTS; s++)
                rd_tuple_reg[s] <= cur_tuple[s];
        end
    end

    // output register
    logic    out_valid_reg, out_valid_next;
    kind_t   out_kind_reg;
    totals_t out_val_reg;
    count_t  out_count_reg;
    logic    out_last_reg;
    tuple_t  sel_tuple;

    assign sel_tuple = rd_tuple_reg[3'(rd_kind_reg - 3'd1)];

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_kind_reg  <= rd_kind_reg;
            out_count_reg <= rd_count_reg;
            out_last_reg  <= (rd_kind_reg == KIND_MAX_FLUSH);
            if (rd_kind_reg == KIND_TOTALS)
                out_val_reg <= rd_totals_reg;
            else
            begin
                out_val_reg[0] <= 48'(sel_tuple[0]);
                out_val_reg[1] <= 48'(sel_tuple[1]);
                out_val_reg[2] <= 48'(sel_tuple[2]);
            end
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.stat_kind    = out_kind_reg;
    assign result.value_dma    = out_val_reg[0];
    assign result.value_busy   = out_val_reg[1];
    assign result.value_flush  = out_val_reg[2];
    assign result.sample_count = out_count_reg;
    assign result.last         = out_last_reg;

endmodule

@@ hdl/lsb_checker.sv @@
module lsb_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 result_valid,
    input logic                 result_ready,
    input logic [2:0]           stat_kind,
    input lsb_pkg::total_t      value_dma,
    input lsb_pkg::count_t      sample_count,
    input logic                 last
);
    import lsb_pkg::*;

    logic   result_take;
    kind_t  exp_kind_reg, exp_kind_next;
    count_t bin_count_reg;

    assign result_take = result_valid && result_ready;

    always_comb
    begin
        exp_kind_next = exp_kind_reg;
        if (result_take)
            exp_kind_next = last ? KIND_TOTALS : kind_t'(exp_kind_reg + 3'd1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            exp_kind_reg <= KIND_TOTALS;
        else
            exp_kind_reg <= exp_kind_next;
    end

    always_ff @(posedge clk)
    begin
        if (result_take && stat_kind == KIND_TOTALS)
            bin_count_reg <= sample_count;
    end

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(stat_kind) && $stable(value_dma) && $stable(last))
        else $error("result changed while stalled");

    // kinds come in order, restarting after last
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> stat_kind == exp_kind_reg)
        else $error("result kind out of sequence");

    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (last == (stat_kind == KIND_MAX_FLUSH)))
        else $error("last not on final kind");

    // one bin snapshot per read
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && stat_kind != KIND_TOTALS |-> sample_count == bin_count_reg)
        else $error("sample count changed within a read");

endmodule

bind latency_stats_per_size_bin lsb_checker u_lsb_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .stat_kind    (result.stat_kind),
    .value_dma    (result.value_dma),
    .sample_count (result.sample_count),
    .last         (result.last)
);
